FILE: design/mlbpe_pkg.sv
// Package for the multi-LED blink pattern engine.
// Holds bank sizes, pulse limits, command codes and sequencer state type.
// No dependencies.
`default_nettype none
package mlbpe_pkg;

    localparam int LED_COUNT = 8;
    localparam int MAIN_LED  = 0;
    localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam bit MAIN_OK   = (MAIN_LED < LED_COUNT);

    localparam int EL_W  = 17;
    localparam int ON_W  = 16;
    localparam int CNT_W = 8;
    localparam int PIN_W = 8;

    localparam logic [ON_W-1:0]  PULSE_MIN      = 16'd50;
    localparam logic [ON_W-1:0]  PULSE_MAX      = 16'd10000;
    localparam logic [CNT_W-1:0] REPEAT_MAX     = 8'd254;
    localparam logic [CNT_W-1:0] REPEAT_ENDLESS = 8'd255;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_BLINK = 3'd1,
        CMD_GEN   = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_LEVEL = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_CMD
    } t_state;

endpackage
`default_nettype wire

FILE: design/multi_led_blink_pattern_engine.sv
// Multi-LED blink pattern engine: per-LED pulse timers behind one shared update unit.
// Depends on mlbpe_pkg.
//
//  channel | signals                                               | handshake
//  --------+-------------------------------------------------------+--------------------
//  command | i_command i_led_index i_high_ms i_low_ms              | start & !busy
//          | i_repeat_count i_level                                |
//  result  | o_pin_levels                                          | o_valid, one cycle
//
// A tick visits one LED per cycle, then raises the result strobe
// in the cycle busy drops.
// All other commands pass once through the update unit and give no result.
// Reset clears every LED's timers; the main LED's static level comes up one.
// The receiver cannot stall; results are never held.
`default_nettype none
module multi_led_blink_pattern_engine
    import mlbpe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire logic [2:0]       i_command,
    input  wire logic [3:0]       i_led_index,
    input  wire logic [15:0]      i_high_ms,
    input  wire logic [15:0]      i_low_ms,
    input  wire logic [15:0]      i_repeat_count,
    input  wire logic             i_level,
    output      logic             o_valid,
    output      logic [PIN_W-1:0] o_pin_levels
);

    localparam logic [IDX_W-1:0] MAIN_IDX = IDX_W'(MAIN_LED);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [3:0]       r_idx;
    logic [15:0]      r_hi, r_lo, r_rep;
    logic             r_lvl;
    logic [IDX_W-1:0] r_cnt;
    logic [PIN_W-1:0] r_pins, n_pins;
    logic             r_valid;
    logic [PIN_W-1:0] r_out;

    logic             r_static  [LED_COUNT];
    logic [EL_W-1:0]  r_elapsed [LED_COUNT];
    logic [ON_W-1:0]  r_on      [LED_COUNT];
    logic [EL_W-1:0]  r_period  [LED_COUNT];
    logic [CNT_W-1:0] r_blinks  [LED_COUNT];

    logic             accept;
    logic [IDX_W-1:0] sel;
    logic             idx_ok;
    logic             cur_st;
    logic [EL_W-1:0]  cur_el, cur_per;
    logic [ON_W-1:0]  cur_on;
    logic [CNT_W-1:0] cur_bl;
    logic             running;
    logic [EL_W-1:0]  el_inc;
    logic [CNT_W-1:0] bl_dec;
    logic [ON_W-1:0]  hi_min, lo_min, blink_ms;
    logic             pin;
    logic             we;
    logic             w_st;
    logic [EL_W-1:0]  w_el, w_per;
    logic [ON_W-1:0]  w_on;
    logic [CNT_W-1:0] w_bl;

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_pin_levels = r_out;

    assign idx_ok = 5'(r_idx) < 5'(LED_COUNT);

    always_comb begin
        if (r_state == ST_TICK) begin
            sel = r_cnt;
        end else if (r_cmd == CMD_GEN || r_cmd == CMD_STOP) begin
            sel = MAIN_IDX;
        end else begin
            sel = r_idx[IDX_W-1:0];
        end
    end

    assign cur_st  = r_static[sel];
    assign cur_el  = r_elapsed[sel];
    assign cur_on  = r_on[sel];
    assign cur_per = r_period[sel];
    assign cur_bl  = r_blinks[sel];

    // shared update unit
    assign running = cur_el < cur_per;
    assign el_inc  = cur_el + EL_W'(1);
    assign bl_dec  = cur_bl - CNT_W'(1);
    assign hi_min  = (r_hi < PULSE_MIN) ? PULSE_MIN : r_hi;
    assign lo_min  = (r_lo < PULSE_MIN) ? PULSE_MIN : r_lo;
    assign blink_ms = (hi_min > PULSE_MAX) ? PULSE_MAX : hi_min;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = accept ? ((t_cmd'(i_command) == CMD_TICK) ? ST_TICK : ST_CMD)
                                      : ST_IDLE;
            ST_TICK: n_state = (r_cnt == LAST_IDX) ? ST_IDLE : ST_TICK;
            ST_CMD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        we     = 1'b0;
        w_st   = cur_st;
        w_el   = cur_el;
        w_on   = cur_on;
        w_per  = cur_per;
        w_bl   = cur_bl;
        pin    = cur_st;
        n_pins = r_pins;
        case (r_state)
            ST_TICK: begin
                we = 1'b1;
                if (running) begin
                    w_el = el_inc;
                    if (el_inc < EL_W'(cur_on)) begin
                        pin = ~cur_st;
                    end
                end else if (cur_bl == REPEAT_ENDLESS) begin
                    w_el = '0;
                end else if (cur_bl != '0) begin
                    w_bl = bl_dec;
                    if (bl_dec != '0) begin
                        w_el = '0;
                    end
                end
                for (int k = 0; k < PIN_W; k++) begin
                    if (int'(r_cnt) == k) begin
                        n_pins[k] = pin;
                    end
                end
            end
            ST_CMD: begin
                case (r_cmd)
                    CMD_BLINK: begin
                        if (idx_ok && cur_bl == '0 && !running) begin
                            we    = 1'b1;
                            w_el  = '0;
                            w_on  = blink_ms;
                            w_per = EL_W'({blink_ms, 2'b00});
                        end
                    end
                    CMD_GEN: begin
                        we    = MAIN_OK;
                        w_el  = '0;
                        w_on  = hi_min;
                        w_per = EL_W'(hi_min) + EL_W'(lo_min);
                        if (r_rep == '0) begin
                            w_bl = REPEAT_ENDLESS;
                        end else if (r_rep > 16'(REPEAT_MAX)) begin
                            w_bl = REPEAT_MAX;
                        end else begin
                            w_bl = r_rep[CNT_W-1:0];
                        end
                    end
                    CMD_STOP: begin
                        we   = MAIN_OK;
                        w_bl = '0;
                    end
                    CMD_LEVEL: begin
                        we   = idx_ok;
                        w_st = r_lvl;
                    end
                    default: we = 1'b0;
                endcase
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd   <= CMD_TICK;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < LED_COUNT; k++) begin
                r_static[k]  <= MAIN_OK && (k == MAIN_LED);
                r_elapsed[k] <= '0;
                r_on[k]      <= '0;
                r_period[k]  <= '0;
                r_blinks[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (accept) begin
                r_cmd  <= t_cmd'(i_command);
                r_idx  <= i_led_index;
                r_hi   <= i_high_ms;
                r_lo   <= i_low_ms;
                r_rep  <= i_repeat_count;
                r_lvl  <= i_level;
                r_cnt  <= '0;
                r_pins <= '0;
            end
            if (r_state == ST_TICK) begin
                r_cnt  <= r_cnt + IDX_W'(1);
                r_pins <= n_pins;
                if (r_cnt == LAST_IDX) begin
                    r_valid <= 1'b1;
                    r_out   <= n_pins;
                end
            end
            if (we) begin
                r_static[sel]  <= w_st;
                r_elapsed[sel] <= w_el;
                r_on[sel]      <= w_on;
                r_period[sel]  <= w_per;
                r_blinks[sel]  <= w_bl;
            end
        end
    end

    a_valid_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_TICK) && $past(r_cnt == LAST_IDX))
        else $error("result strobe without a finished tick sweep");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_tick_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> (r_cmd == CMD_TICK))
        else $error("tick sweep running for another command");

    a_unused_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pin_levels >> LED_COUNT) == '0))
        else $error("pin reported for an LED beyond the bank");

endmodule
`default_nettype wire

FILE: test/multi_led_blink_pattern_engine_tb.sv
// Testbench for multi_led_blink_pattern_engine: directed table, then random command mix.
// Every tick result is checked against a local model of the LED bank timers, or against a directed row's expected pins.
// Depends on mlbpe_pkg and the engine RTL.
`timescale 1ns / 1ps
module multi_led_blink_pattern_engine_tb
    import mlbpe_pkg::*;
();

    localparam int          ITEM_TARGET   = 1150;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          TICK_LATENCY  = LED_COUNT + 1;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  idx;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] rep;
        logic        lvl;
    } t_item;

    typedef struct packed {
        t_item            it;
        bit               typed;
        logic [PIN_W-1:0] pins;
    } t_row;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic [2:0]       i_command      = '0;
    logic [3:0]       i_led_index    = '0;
    logic [15:0]      i_high_ms      = '0;
    logic [15:0]      i_low_ms       = '0;
    logic [15:0]      i_repeat_count = '0;
    logic             i_level        = 1'b0;
    logic             busy;
    logic             o_valid;
    logic [PIN_W-1:0] o_pin_levels;

    logic             bank_level  [LED_COUNT];
    logic [EL_W-1:0]  led_elapsed [LED_COUNT];
    logic [ON_W-1:0]  led_on      [LED_COUNT];
    logic [EL_W-1:0]  led_period  [LED_COUNT];
    logic [CNT_W-1:0] led_left    [LED_COUNT];

    logic [PIN_W-1:0] pins_due[$];
    int               mismatches = 0;
    int               items_sent = 0;
    int unsigned      cycle_cnt  = 0;

    multi_led_blink_pattern_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_led_index    (i_led_index),
        .i_high_ms      (i_high_ms),
        .i_low_ms       (i_low_ms),
        .i_repeat_count (i_repeat_count),
        .i_level        (i_level),
        .o_valid        (o_valid),
        .o_pin_levels   (o_pin_levels)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [PIN_W-1:0] got,
                                 input logic [PIN_W-1:0] want);
        $display("[%0t] %s: got %02h, want %02h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : pin_check
        logic [PIN_W-1:0] want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pins_due.size() == 0) begin
                flag_mismatch("pin levels with no tick pending", o_pin_levels, '0);
            end else begin
                want = pins_due.pop_front();
                if (o_pin_levels !== want)
                    flag_mismatch("pin levels", o_pin_levels, want);
            end
        end
    end

    function automatic void reset_bank();
        for (int n = 0; n < LED_COUNT; n++) begin
            bank_level[n]  = 1'b0;
            led_elapsed[n] = '0;
            led_on[n]      = '0;
            led_period[n]  = '0;
            led_left[n]    = '0;
        end
        if (MAIN_OK)
            bank_level[MAIN_LED] = 1'b1;
    endfunction

    // Applies one command to the bank; returns 1 when it yields pin levels.
    function automatic bit step_bank(input t_item it, output logic [PIN_W-1:0] pins);
        logic [ON_W-1:0]  pulse;
        logic [ON_W-1:0]  off_v;
        logic [15:0]      cnt;
        logic             p;
        logic [IDX_W-1:0] sel;
        pins = '0;
        sel  = it.idx[IDX_W-1:0];
        case (it.cmd)
            CMD_TICK: begin
                for (int n = 0; n < LED_COUNT; n++) begin
                    p = bank_level[n];
                    if (led_elapsed[n] < led_period[n]) begin
                        led_elapsed[n] = led_elapsed[n] + 1'b1;
                        if (led_elapsed[n] < EL_W'(led_on[n]))
                            p = ~p;
                    end else if (led_left[n] == REPEAT_ENDLESS) begin
                        led_elapsed[n] = '0;
                    end else if (led_left[n] != '0) begin
                        led_left[n] = led_left[n] - 1'b1;
                        if (led_left[n] != '0)
                            led_elapsed[n] = '0;
                    end
                    if (n < PIN_W)
                        pins[n] = p;
                end
                return 1'b1;
            end
            CMD_BLINK: begin
                if (it.idx < LED_COUNT) begin
                    pulse = (it.hi < PULSE_MIN) ? PULSE_MIN : it.hi;
                    if (pulse > PULSE_MAX)
                        pulse = PULSE_MAX;
                    if (led_left[sel] == '0 && led_elapsed[sel] >= led_period[sel]) begin
                        led_elapsed[sel] = '0;
                        led_on[sel]      = pulse;
                        led_period[sel]  = EL_W'(pulse) << 2;
                    end
                end
            end
            CMD_GEN: begin
                if (MAIN_OK) begin
                    pulse = (it.hi < PULSE_MIN) ? PULSE_MIN : it.hi;
                    off_v = (it.lo < PULSE_MIN) ? PULSE_MIN : it.lo;
                    cnt   = (it.rep > REPEAT_MAX) ? 16'(REPEAT_MAX) : it.rep;
                    led_elapsed[MAIN_LED] = '0;
                    led_on[MAIN_LED]      = pulse;
                    led_period[MAIN_LED]  = EL_W'(pulse) + EL_W'(off_v);
                    led_left[MAIN_LED]    = (cnt == '0) ? REPEAT_ENDLESS : CNT_W'(cnt);
                end
            end
            CMD_STOP: begin
                if (MAIN_OK)
                    led_left[MAIN_LED] = '0;
            end
            CMD_LEVEL: begin
                if (it.idx < LED_COUNT)
                    bank_level[sel] = it.lvl;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item rand_item(input logic [2:0] cmd);
        t_item it;
        it.cmd = cmd;
        it.idx = 4'($urandom);
        it.hi  = 16'($urandom);
        it.lo  = 16'($urandom);
        it.rep = 16'($urandom);
        it.lvl = 1'($urandom);
        return it;
    endfunction

    function automatic t_row mk_row(input logic [2:0] cmd, input logic [3:0] idx,
                                    input logic [15:0] hi, input logic [15:0] lo,
                                    input logic [15:0] rep, input logic lvl,
                                    input bit typed, input logic [PIN_W-1:0] pins);
        t_row r;
        r.it    = '{cmd: cmd, idx: idx, hi: hi, lo: lo, rep: rep, lvl: lvl};
        r.typed = typed;
        r.pins  = pins;
        return r;
    endfunction

    task automatic send_item(input t_item it, input bit typed,
                             input logic [PIN_W-1:0] typed_pins, input int gap);
        logic [PIN_W-1:0] pins;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= it.cmd;
        i_led_index    <= it.idx;
        i_high_ms      <= it.hi;
        i_low_ms       <= it.lo;
        i_repeat_count <= it.rep;
        i_level        <= it.lvl;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (step_bank(it, pins))
            pins_due.push_back(typed ? typed_pins : pins);
        items_sent++;
    endtask

    task automatic send_rand(input t_item it, input bit quiet);
        send_item(it, 1'b0, '0, pick_gap(quiet));
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pins_due.size() != 0);
    endtask

    t_row dir_rows[25];

    initial begin : stimulus
        t_item it;
        int    pick;
        int    burst;
        int    next_drain;
        bit    quiet;

        // reset values, explicit level, out-of-range LEDs, unused codes
        dir_rows[0]  = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b1, 8'h01);
        dir_rows[1]  = mk_row(CMD_LEVEL, 4'd7,  '0, '0, '0, 1'b1, 1'b0, '0);
        dir_rows[2]  = mk_row(CMD_LEVEL, 4'd15, '1, '1, '1, 1'b1, 1'b0, '0);
        dir_rows[3]  = mk_row(CMD_LEVEL, 4'd8,  '0, '0, '0, 1'b1, 1'b0, '0);
        dir_rows[4]  = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b1, 8'h81);
        dir_rows[5]  = mk_row(CMD_LEVEL, 4'd0,  '0, '0, '0, 1'b0, 1'b0, '0);
        dir_rows[6]  = mk_row(CMD_TICK,  4'd15, '1, '1, '1, 1'b1, 1'b1, 8'h80);
        dir_rows[7]  = mk_row(CMD_UNUSED_LO,        4'd0, '1, '1, '1, 1'b1, 1'b0, '0);
        dir_rows[8]  = mk_row(CMD_UNUSED_LO + 3'd1, 4'd7, '1, '1, '1, 1'b0, 1'b0, '0);
        dir_rows[9]  = mk_row(CMD_UNUSED_HI,        4'd0, '0, '0, '0, 1'b1, 1'b0, '0);
        dir_rows[10] = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b1, 8'h80);
        // blink clamps, refused blink, ignored index
        dir_rows[11] = mk_row(CMD_BLINK, 4'd3,  16'd0,     '0, '0, 1'b0, 1'b0, '0);
        dir_rows[12] = mk_row(CMD_BLINK, 4'd1,  16'hFFFF,  '0, '0, 1'b0, 1'b0, '0);
        dir_rows[13] = mk_row(CMD_BLINK, 4'd1,  16'd100,   '0, '0, 1'b0, 1'b0, '0);
        dir_rows[14] = mk_row(CMD_BLINK, 4'd15, 16'd60,    '0, '0, 1'b0, 1'b0, '0);
        dir_rows[15] = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b1, 8'h8A);
        // generate: endless, saturated count, stop, single pulse
        dir_rows[16] = mk_row(CMD_GEN,   4'd0,  16'd0,    16'd0,    16'd0,    1'b0, 1'b0, '0);
        dir_rows[17] = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b0, '0);
        dir_rows[18] = mk_row(CMD_GEN,   4'd0,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0);
        dir_rows[19] = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b0, '0);
        dir_rows[20] = mk_row(CMD_STOP,  4'd0,  '0, '0, '0, 1'b0, 1'b0, '0);
        dir_rows[21] = mk_row(CMD_GEN,   4'd0,  16'd51,   16'd49,   16'd1,    1'b0, 1'b0, '0);
        dir_rows[22] = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b0, '0);
        dir_rows[23] = mk_row(CMD_BLINK, 4'd0,  16'd50,   '0, '0, 1'b0, 1'b0, '0);
        dir_rows[24] = mk_row(CMD_TICK,  4'd0,  '0, '0, '0, 1'b0, 1'b0, '0);

        reset_bank();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].pins, pick_gap(1'b0));
        drain();

        next_drain = items_sent + 300;
        while (items_sent < ITEM_TARGET) begin
            pick  = $urandom_range(0, 99);
            quiet = ($urandom_range(0, 4) == 0);
            if (pick < 45) begin
                burst = $urandom_range(1, 30);
                repeat (burst) send_rand(rand_item(CMD_TICK), quiet);
            end else if (pick < 57) begin
                it = rand_item(CMD_BLINK);
                if ($urandom_range(0, 7) != 0)
                    it.idx = 4'($urandom_range(0, LED_COUNT - 1));
                it.hi = 16'($urandom_range(0, 80));
                send_rand(it, quiet);
            end else if (pick < 59) begin
                // long pulses mostly go to absent LEDs so the bank does not lock up
                it = rand_item(CMD_BLINK);
                if ($urandom_range(0, 2) != 0)
                    it.idx = 4'($urandom_range(LED_COUNT, 15));
                send_rand(it, quiet);
            end else if (pick < 67) begin
                it     = rand_item(CMD_GEN);
                it.hi  = 16'($urandom_range(0, 70));
                it.lo  = 16'($urandom_range(0, 70));
                it.rep = 16'($urandom_range(0, 4));
                send_rand(it, quiet);
            end else if (pick < 69) begin
                send_rand(rand_item(CMD_GEN), quiet);
            end else if (pick < 74) begin
                send_rand(rand_item(CMD_STOP), quiet);
            end else if (pick < 84) begin
                send_rand(rand_item(CMD_LEVEL), quiet);
            end else if (pick < 87) begin
                send_rand(rand_item(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))), quiet);
            end else begin
                // counted pattern followed by a burst of ticks, which may not run it out
                it     = rand_item(CMD_GEN);
                it.hi  = 16'($urandom_range(0, 60));
                it.lo  = 16'($urandom_range(0, 60));
                it.rep = 16'($urandom_range(1, 3));
                send_rand(it, quiet);
                burst = $urandom_range(60, 250);
                if (burst > ITEM_TARGET - items_sent)
                    burst = ITEM_TARGET - items_sent;
                repeat (burst) send_rand(rand_item(CMD_TICK), quiet);
            end
            if (items_sent >= next_drain) begin
                drain();
                next_drain = items_sent + 300;
            end
        end

        drain();
        repeat (4 * TICK_LATENCY) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
